>>> src/ctl_pkg.sv
package ctl_pkg;

	localparam int TOKEN_CHARS = 8;
	localparam int KW_COUNT = 32;
	localparam int OP_COUNT = 25;

	// result kinds
	localparam logic [2:0] KIND_NUMBER     = 3'd0;
	localparam logic [2:0] KIND_KEYWORD    = 3'd1;
	localparam logic [2:0] KIND_IDENTIFIER = 3'd2;
	localparam logic [2:0] KIND_OPERATOR   = 3'd3;
	localparam logic [2:0] KIND_BAD_OPER   = 3'd4;
	localparam logic [2:0] KIND_SPECIAL    = 3'd5;

	// characters of interest
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} lex_in_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [63:0] token_text;
		logic [5:0]  token_length;
		logic        truncated;
		logic [31:0] number_value;
		logic        last_of_run;
	} lex_out_t;

	localparam logic [63:0] KW_STR [KW_COUNT] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof",
		"static", "struct", "switch", "typedef", "union", "unsigned", "void",
		"volatile", "while"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
		4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
		4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
		4'd8, 4'd5
	};

	localparam logic [63:0] OP_STR [OP_COUNT] = '{
		"+", "-", "*", "/", "=", "!", "&", "|", "^", ">", "<",
		"+=", "-=", "*=", "/=", "==", "!=", ">=", "<=", "&&", "||",
		"<<", ">>", "++", "--"
	};
	localparam logic [3:0] OP_LEN [OP_COUNT] = '{
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd2, 4'd2, 4'd2
	};

	// string literals hold the first character highest; flip so it sits in byte 0
	function automatic logic [63:0] pack_text(logic [63:0] s, logic [3:0] len);
		logic [63:0] r;
		int n;
		r = '0;
		n = int'(len);
		for (int i = 0; i < TOKEN_CHARS; i++) begin
			if (i < n) begin
				r[8*i +: 8] = s[8*(n-1-i) +: 8];
			end
		end
		return r;
	endfunction

	function automatic logic is_keyword(logic [63:0] text, logic [5:0] count);
		logic found;
		found = 1'b0;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (count == {2'b00, KW_LEN[i]} && text == pack_text(KW_STR[i], KW_LEN[i])) begin
				found = 1'b1;
			end
		end
		return found;
	endfunction

	function automatic logic is_operator(logic [63:0] text, logic [5:0] count);
		logic found;
		found = 1'b0;
		for (int i = 0; i < OP_COUNT; i++) begin
			if (count == {2'b00, OP_LEN[i]} && text == pack_text(OP_STR[i], OP_LEN[i])) begin
				found = 1'b1;
			end
		end
		return found;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_oper_char(logic [7:0] c);
		return c == 8'h2B || c == 8'h2D || c == CH_STAR || c == CH_SLASH ||
			c == 8'h3D || c == 8'h3E || c == 8'h3C || c == 8'h21 ||
			c == 8'h26 || c == 8'h7C || c == 8'h5E;
	endfunction

endpackage

>>> src/c_token_lexer_top.sv
// Channel   Dir  Word type   Content
// byte_*    in   lex_in_t    one source byte, or the end marker
// tok_*     out  lex_out_t   one classified token
//
// Each accepted byte is handled at once: the lexer state advances at the accept edge and the
// zero, one or two tokens that the byte completes are written into a four-word result
// queue in that same edge. byte_ready is high while the queue has room for two words,
// so bytes flow one per clock as long as tokens are drained about as fast. A stall on
// tok_ready only fills the queue; byte_ready drops when fewer than two slots are free.
// arst_n clears the lexer to idle with an empty buffer and empties the queue.
module c_token_lexer_top
	import ctl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  lex_in_t  byte_word,
	output logic     tok_valid,
	input  logic     tok_ready,
	output lex_out_t tok_word
);

	typedef enum logic [2:0] {
		M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_NUM, M_WORD, M_OPER
	} mode_t;

	// lexer state
	mode_t       mode_q;
	logic [63:0] text_q;
	logic [5:0]  count_q;
	logic [31:0] accum_q;

	// result queue
	lex_out_t    queue_q [4];
	logic [1:0]  head_q;
	logic [1:0]  tail_q;
	logic [2:0]  fill_q;

	logic        take;
	logic        give;

	mode_t       mode_d;
	logic [63:0] text_d;
	logic [5:0]  count_d;
	logic [31:0] accum_d;

	logic        fl_valid;
	lex_out_t    fl_res;
	logic        st_valid;
	lex_out_t    st_res;
	mode_t       st_mode;
	logic        st_begin;
	logic        do_flush;
	logic        do_start;
	logic        do_append;
	logic [63:0] app_text;
	logic [5:0]  app_count;
	logic [7:0]  c;

	logic [1:0]  n_res;
	lex_out_t    res_a;
	lex_out_t    res_b;

	assign c = byte_word.ch;
	assign take = byte_valid && byte_ready;
	assign give = tok_valid && tok_ready;
	assign byte_ready = (fill_q <= 3'd2);
	assign tok_valid = (fill_q != 3'd0);
	assign tok_word = queue_q[head_q];

	// token that the pending state yields when it is closed
	always_comb begin
		fl_valid = 1'b0;
		fl_res = '0;
		fl_res.token_text = text_q;
		fl_res.token_length = count_q;
		fl_res.truncated = (count_q > 6'(TOKEN_CHARS));
		case (mode_q)
			M_SLASH: begin
				fl_valid = 1'b1;
				fl_res.token_kind = KIND_OPERATOR;
				fl_res.token_text = {56'd0, CH_SLASH};
				fl_res.token_length = 6'd1;
				fl_res.truncated = 1'b0;
			end
			M_NUM: begin
				fl_valid = 1'b1;
				fl_res.token_kind = KIND_NUMBER;
				fl_res.number_value = accum_q;
			end
			M_WORD: begin
				fl_valid = 1'b1;
				fl_res.token_kind = is_keyword(text_q, count_q) ? KIND_KEYWORD
					: KIND_IDENTIFIER;
			end
			M_OPER: begin
				fl_valid = 1'b1;
				fl_res.token_kind = is_operator(text_q, count_q) ? KIND_OPERATOR
					: KIND_BAD_OPER;
			end
			default: begin
				fl_valid = 1'b0;
			end
		endcase
	end

	// what the byte does when it opens a token from idle
	always_comb begin
		st_valid = 1'b0;
		st_begin = 1'b0;
		st_mode = M_IDLE;
		st_res = '0;
		st_res.token_kind = KIND_SPECIAL;
		st_res.token_text = {56'd0, c};
		st_res.token_length = 6'd1;
		if (c == CH_SLASH) begin
			st_mode = M_SLASH;
		end else if (is_digit(c)) begin
			st_mode = M_NUM;
			st_begin = 1'b1;
		end else if (is_letter(c)) begin
			st_mode = M_WORD;
			st_begin = 1'b1;
		end else if (is_oper_char(c)) begin
			st_mode = M_OPER;
			st_begin = 1'b1;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
			st_mode = M_IDLE;
		end else begin
			st_valid = 1'b1;
		end
	end

	// append the byte to the pending text; bytes past the buffer are dropped
	always_comb begin
		app_text = text_q;
		for (int i = 0; i < TOKEN_CHARS; i++) begin
			if (count_q == 6'(i)) begin
				app_text[8*i +: 8] = c;
			end
		end
		app_count = (count_q == 6'd63) ? count_q : count_q + 6'd1;
	end

	// choose the mode step
	always_comb begin
		do_flush = 1'b0;
		do_start = 1'b0;
		do_append = 1'b0;
		mode_d = mode_q;
		if (byte_word.end_of_input) begin
			do_flush = 1'b1;
			mode_d = M_IDLE;
		end else begin
			case (mode_q)
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_d = M_LINE;
					end else if (c == CH_STAR) begin
						mode_d = M_BLOCK;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_LINE: begin
					if (c == CH_NEWLINE) begin
						mode_d = M_IDLE;
					end
				end
				M_BLOCK: begin
					if (c == CH_STAR) begin
						mode_d = M_STAR;
					end
				end
				M_STAR: begin
					if (c == CH_SLASH) begin
						mode_d = M_IDLE;
					end else if (c != CH_STAR) begin
						mode_d = M_BLOCK;
					end
				end
				M_NUM: begin
					if (is_digit(c)) begin
						do_append = 1'b1;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_WORD: begin
					if (is_digit(c) || is_letter(c) || c == CH_UNDER || c == CH_DOLLAR) begin
						do_append = 1'b1;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				M_OPER: begin
					if (is_oper_char(c)) begin
						do_append = 1'b1;
					end else begin
						do_flush = 1'b1;
						do_start = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
			if (do_start) begin
				mode_d = st_mode;
			end
		end
	end

	// buffer and accumulator next values
	always_comb begin
		text_d = text_q;
		count_d = count_q;
		accum_d = accum_q;
		if (do_append) begin
			text_d = app_text;
			count_d = app_count;
			accum_d = (accum_q << 3) + (accum_q << 1) + {24'd0, c - CH_ZERO};
		end else if (do_start && st_begin) begin
			text_d = {56'd0, c};
			count_d = 6'd1;
			accum_d = is_digit(c) ? {24'd0, c - CH_ZERO} : 32'd0;
		end
	end

	// order the results: closed token first, then a special symbol
	always_comb begin
		logic fv;
		logic sv;
		fv = do_flush && fl_valid;
		sv = do_start && st_valid;
		res_a = fv ? fl_res : st_res;
		res_b = st_res;
		res_a.last_of_run = !(fv && sv);
		res_b.last_of_run = 1'b1;
		n_res = 2'(fv) + 2'(sv);
	end

	// lexer state and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			text_q <= '0;
			count_q <= '0;
			accum_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				text_q <= text_d;
				count_q <= count_d;
				accum_q <= accum_d;
				tail_q <= tail_q + n_res;
			end
			if (give) begin
				head_q <= head_q + 2'd1;
			end
			fill_q <= fill_q + (take ? {1'b0, n_res} : 3'd0) - (give ? 3'd1 : 3'd0);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (take) begin
			if (n_res != 2'd0) begin
				queue_q[tail_q] <= res_a;
			end
			if (n_res == 2'd2) begin
				queue_q[tail_q + 2'd1] <= res_b;
			end
		end
	end

endmodule
